FILE: hdl/ffsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit segment allocator: beat
// layout widths, result codes, table entry layout, controller states and the
// command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ffsa_pkg;

   // beat field widths
   localparam int SIZE_W      = 16;
   localparam int HANDLE_W    = 16;
   localparam int STATUS_W    = 3;
   localparam int COUNT_OUT_W = 6;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;

   // largest size a merged segment may reach
   localparam logic [SIZE_W:0] SIZE_LIMIT = 17'h0FFFF;

   // request kinds carried in req_tuser
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // result codes carried in rsp_tuser
   typedef enum logic [STATUS_W-1:0] {
      RSP_ALLOCATED  = 3'd0,
      RSP_FREED      = 3'd1,
      RSP_NOT_FOUND  = 3'd2,
      RSP_TABLE_FULL = 3'd3,
      RSP_EXHAUSTED  = 3'd4
   } rsp_status_type;

   // one segment table entry
   typedef struct packed {
      logic              is_free;
      logic [SIZE_W-1:0] size;
   } seg_entry_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_CHK,
      ST_SCAN_EV,
      ST_INS_CHK,
      ST_INS_WR,
      ST_FREE_EV,
      ST_DROP_CHK,
      ST_DROP_WR,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request, restart scan
      logic scan_rd;   // read entry at scan index
      logic scan_adv;  // step past current entry
      logic take;      // grant the fitting entry
      logic ins_rd;    // read entry below insert pointer
      logic ins_wr;    // move entry up by one
      logic ins_put;   // place split remainder
      logic tail;      // resolve end of scan
      logic match;     // latch matched entry, read its successor
      logic merge;     // write freed and merged entry
      logic drop_rd;   // read entry above the gap
      logic drop_wr;   // move entry down into the gap
      logic drop_end;  // shrink the table
      logic emit;      // load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_free_op;
      logic at_end;
      logic fit;
      logic match;
      logic split;
      logic merge_drop;
      logic ins_done;
      logic drop_done;
      logic out_hold;
   } stat_type;

endpackage

FILE: hdl/first_fit_segment_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit
// First-fit heap segment allocator with split on allocate and coalescing on
// free; the start offset of a segment is its handle.
// ----------------------------------------------------------------------------
// usage:
//   req beat: tuser = 0 allocate / 1 free, tdata = size and handle.
//   rsp beat: tuser = result code, tdata = granted offset and segment count.
//   one rsp beat per req beat, in order. a new req beat is taken only when
//   the previous operation has finished (req_tready high in idle).
// table access:
//   the table sits in a single read, single write memory with registered
//   read, so the scan visits each segment in a read state (ST_SCAN_CHK)
//   and an evaluate state (ST_SCAN_EV). an allocate that splits shifts
//   entries up (ST_INS_CHK, ST_INS_WR) and a free that merges shifts
//   entries down (ST_DROP_CHK, ST_DROP_WR), one read and one write each.
// reset:
//   empties the table and the heap and drops any pending rsp beat; no
//   clearing pass is needed.
// stall:
//   a finished result waits in the output register; the block may take the
//   next req beat meanwhile and holds its next result until the slot frees.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_unit #(
   parameter int MAX_SEGMENTS = 32,
   parameter int HEAP_BYTES   = 65536
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ffsa_pkg::REQ_TDATA_W-1:0] req_tdata,  // num_bytes, block_offset
   input  logic                             req_tuser,  // func
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ffsa_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // granted_offset, segments_in_use
   output logic [ffsa_pkg::STATUS_W-1:0]    rsp_tuser   // status
);
   import ffsa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ffsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ffsa_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .HEAP_BYTES   (HEAP_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // one operation at a time: an accepted beat blocks the next
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while an operation is in progress");

   // offset field is zero unless the request was granted
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != RSP_ALLOCATED) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("nonzero offset on a result that grants nothing");

   // a full-table result reports a full table
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == RSP_TABLE_FULL)
         |-> (rsp_tdata[21:16] == COUNT_OUT_W'(MAX_SEGMENTS)))
      else $error("table full reported with free table entries");

   // result beats only come from the controller's hand-off
   a_emit_only: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.emit))
      else $error("result beat raised without a hand-off");

endmodule

FILE: hdl/ffsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer of the allocator: walks the segment table, steers the insert and
// remove shifts and hands finished results to the output register.
// ----------------------------------------------------------------------------
module ffsa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  ffsa_pkg::stat_type stat,
   output ffsa_pkg::cmd_type  cmd
);
   import ffsa_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            state_in = stat.at_end ? ST_FINISH : ST_SCAN_EV;
         end
         ST_SCAN_EV: begin
            priority if (stat.is_free_op && stat.match) begin
               state_in = ST_FREE_EV;
            end else if (!stat.is_free_op && stat.fit) begin
               state_in = stat.split ? ST_INS_CHK : ST_FINISH;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_INS_CHK: begin
            state_in = stat.ins_done ? ST_FINISH : ST_INS_WR;
         end
         ST_INS_WR: begin
            state_in = ST_INS_CHK;
         end
         ST_FREE_EV: begin
            state_in = stat.merge_drop ? ST_DROP_CHK : ST_FINISH;
         end
         ST_DROP_CHK: begin
            state_in = stat.drop_done ? ST_FINISH : ST_DROP_WR;
         end
         ST_DROP_WR: begin
            state_in = ST_DROP_CHK;
         end
         ST_FINISH: begin
            if (!stat.out_hold) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SCAN_CHK: begin
            cmd.tail    = stat.at_end;
            cmd.scan_rd = !stat.at_end;
         end
         ST_SCAN_EV: begin
            priority if (stat.is_free_op && stat.match) begin
               cmd.match = 1'b1;
            end else if (!stat.is_free_op && stat.fit) begin
               cmd.take = 1'b1;
            end else begin
               cmd.scan_adv = 1'b1;
            end
         end
         ST_INS_CHK: begin
            cmd.ins_put = stat.ins_done;
            cmd.ins_rd  = !stat.ins_done;
         end
         ST_INS_WR: begin
            cmd.ins_wr = 1'b1;
         end
         ST_FREE_EV: begin
            cmd.merge = 1'b1;
         end
         ST_DROP_CHK: begin
            cmd.drop_end = stat.drop_done;
            cmd.drop_rd  = !stat.drop_done;
         end
         ST_DROP_WR: begin
            cmd.drop_wr = 1'b1;
         end
         ST_FINISH: begin
            cmd.emit = !stat.out_hold;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: hdl/ffsa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_datapath
// Segment table memory, scan offset and heap top arithmetic, split and merge
// sizes, table shifts and the registered result beat.
// ----------------------------------------------------------------------------
module ffsa_datapath #(
   parameter int MAX_SEGMENTS = 32,
   parameter int HEAP_BYTES   = 65536
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ffsa_pkg::cmd_type                     cmd,
   output ffsa_pkg::stat_type                    stat,
   input  logic [ffsa_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [ffsa_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [ffsa_pkg::STATUS_W-1:0]         rsp_tuser
);
   import ffsa_pkg::*;

   localparam int IDXW = $clog2(MAX_SEGMENTS);
   localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
   localparam int HTW  = $clog2(HEAP_BYTES + 1);
   localparam int SUMW = ((HTW > SIZE_W) ? HTW : SIZE_W) + 1;
   localparam int OCW  = (CNTW > COUNT_OUT_W) ? CNTW : COUNT_OUT_W;

   // segment table
   seg_entry_type mem [MAX_SEGMENTS];
   seg_entry_type rd_data_ff;
   logic          rd_en;
   logic [IDXW-1:0] rd_addr;
   logic          wr_en;
   logic [IDXW-1:0] wr_addr;
   seg_entry_type wr_data;

   // working registers
   logic [CNTW-1:0]   count_ff, count_in;
   logic [HTW-1:0]    heap_top_ff, heap_top_in;
   logic [CNTW-1:0]   idx_ff, idx_in;
   logic [CNTW-1:0]   sp_ff, sp_in;
   logic [1:0]        dd_ff, dd_in;
   logic [HTW-1:0]    off_ff, off_in;
   logic              func_ff, func_in;
   logic [SIZE_W-1:0] want_ff, want_in;
   logic [HANDLE_W-1:0] where_ff, where_in;
   seg_entry_type     prev_ff, prev_in;
   logic [SIZE_W-1:0] cur_size_ff, cur_size_in;
   logic [SIZE_W-1:0] rest_ff, rest_in;
   rsp_status_type    status_ff, status_in;
   logic [HANDLE_W-1:0] grant_ff, grant_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]    rsp_user_ff, rsp_user_in;

   // derived values
   logic [SUMW-1:0]   off_ext, off_next, heap_ext, heap_sum;
   logic [CNTW:0]     idx_p1, sp_pd, sp_m1;
   logic              room, exhausted, next_valid;
   logic              pm, nm;
   logic [SIZE_W:0]   sum_prev, s1, sum_next, s2;
   logic [1:0]        drop_n;
   logic [CNTW:0]     merge_at;
   logic [OCW-1:0]    count_ext;
   logic [SIZE_W-1:0] req_bytes;

   // scan and allocate arithmetic
   always_comb begin
      off_ext    = SUMW'(off_ff);
      off_next   = off_ext + SUMW'(rd_data_ff.size);
      heap_ext   = SUMW'(heap_top_ff);
      heap_sum   = heap_ext + SUMW'(want_ff);
      exhausted  = heap_sum > SUMW'(HEAP_BYTES);
      room       = count_ff < CNTW'(MAX_SEGMENTS);
      idx_p1     = (CNTW+1)'(idx_ff) + (CNTW+1)'(1);
      sp_pd      = (CNTW+1)'(sp_ff) + (CNTW+1)'(dd_ff);
      sp_m1      = (CNTW+1)'(sp_ff) - (CNTW+1)'(1);
      next_valid = idx_p1 < (CNTW+1)'(count_ff);
      count_ext  = OCW'(count_ff);
      req_bytes  = req_tdata[SIZE_W-1:0];
   end

   // merge sizes for a free: predecessor first, then successor
   always_comb begin
      sum_prev = (SIZE_W+1)'(prev_ff.size) + (SIZE_W+1)'(cur_size_ff);
      pm       = (idx_ff != '0) && prev_ff.is_free && (sum_prev <= SIZE_LIMIT);
      s1       = pm ? sum_prev : (SIZE_W+1)'(cur_size_ff);
      sum_next = s1 + (SIZE_W+1)'(rd_data_ff.size);
      nm       = next_valid && rd_data_ff.is_free && (sum_next <= SIZE_LIMIT);
      s2       = nm ? sum_next : s1;
      drop_n   = {1'b0, pm} + {1'b0, nm};
      merge_at = pm ? (CNTW+1)'(idx_ff) : idx_p1;
   end

   // status to controller
   always_comb begin
      stat.is_free_op = (func_ff == FUNC_FREE);
      stat.at_end     = (idx_ff == count_ff);
      stat.fit        = rd_data_ff.is_free && (want_ff <= rd_data_ff.size);
      stat.match      = (off_ext == SUMW'(where_ff));
      stat.split      = (want_ff != rd_data_ff.size) && room;
      stat.merge_drop = (drop_n != 2'd0);
      stat.ins_done   = ((CNTW+1)'(sp_ff) == idx_p1);
      stat.drop_done  = (sp_pd >= (CNTW+1)'(count_ff));
      stat.out_hold   = rsp_valid_ff && !rsp_tready;
   end

   // table port steering
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = idx_ff[IDXW-1:0];
      wr_en   = 1'b0;
      wr_addr = idx_ff[IDXW-1:0];
      wr_data = rd_data_ff;
      if (cmd.scan_rd) begin
         rd_en = 1'b1;
      end
      if (cmd.match) begin
         rd_en   = 1'b1;
         rd_addr = idx_p1[IDXW-1:0];
      end
      if (cmd.ins_rd) begin
         rd_en   = 1'b1;
         rd_addr = sp_m1[IDXW-1:0];
      end
      if (cmd.drop_rd) begin
         rd_en   = 1'b1;
         rd_addr = sp_pd[IDXW-1:0];
      end
      if (cmd.take) begin
         wr_en           = 1'b1;
         wr_data.is_free = 1'b0;
         wr_data.size    = stat.split ? want_ff : rd_data_ff.size;
      end
      if (cmd.ins_wr || cmd.drop_wr) begin
         wr_en   = 1'b1;
         wr_addr = sp_ff[IDXW-1:0];
      end
      if (cmd.ins_put) begin
         wr_en           = 1'b1;
         wr_addr         = sp_ff[IDXW-1:0];
         wr_data.is_free = 1'b1;
         wr_data.size    = rest_ff;
      end
      if (cmd.tail && func_ff == FUNC_ALLOC && room && !exhausted) begin
         wr_en           = 1'b1;
         wr_addr         = count_ff[IDXW-1:0];
         wr_data.is_free = 1'b0;
         wr_data.size    = want_ff;
      end
      if (cmd.merge) begin
         wr_en           = 1'b1;
         wr_addr         = pm ? sp_m1[IDXW-1:0] : idx_ff[IDXW-1:0];
         wr_data.is_free = 1'b1;
         wr_data.size    = s2[SIZE_W-1:0];
      end
      // predecessor index when merging backward
      if (cmd.merge && pm) begin
         wr_addr = idx_ff[IDXW-1:0] - IDXW'(1);
      end
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // working register next values
   always_comb begin
      count_in    = count_ff;
      heap_top_in = heap_top_ff;
      idx_in      = idx_ff;
      sp_in       = sp_ff;
      dd_in       = dd_ff;
      off_in      = off_ff;
      func_in     = func_ff;
      want_in     = want_ff;
      where_in    = where_ff;
      prev_in     = prev_ff;
      cur_size_in = cur_size_ff;
      rest_in     = rest_ff;
      status_in   = status_ff;
      grant_in    = grant_ff;
      if (cmd.load) begin
         func_in  = req_tuser;
         want_in  = (req_bytes == '0) ? SIZE_W'(1) : req_bytes;
         where_in = req_tdata[SIZE_W +: HANDLE_W];
         idx_in   = '0;
         off_in   = '0;
         prev_in  = '0;
         grant_in = '0;
      end
      if (cmd.scan_adv) begin
         off_in  = off_next[HTW-1:0];
         prev_in = rd_data_ff;
         idx_in  = idx_p1[CNTW-1:0];
      end
      if (cmd.take) begin
         grant_in  = off_ext[HANDLE_W-1:0];
         status_in = RSP_ALLOCATED;
         rest_in   = rd_data_ff.size - want_ff;
         sp_in     = count_ff;
      end
      if (cmd.ins_wr) begin
         sp_in = sp_m1[CNTW-1:0];
      end
      if (cmd.ins_put) begin
         count_in = count_ff + CNTW'(1);
      end
      if (cmd.tail) begin
         priority if (func_ff == FUNC_FREE) begin
            status_in = RSP_NOT_FOUND;
         end else if (!room) begin
            status_in = RSP_TABLE_FULL;
         end else if (exhausted) begin
            status_in = RSP_EXHAUSTED;
         end else begin
            status_in   = RSP_ALLOCATED;
            grant_in    = heap_ext[HANDLE_W-1:0];
            heap_top_in = heap_sum[HTW-1:0];
            count_in    = count_ff + CNTW'(1);
         end
      end
      if (cmd.match) begin
         cur_size_in = rd_data_ff.size;
      end
      if (cmd.merge) begin
         status_in = RSP_FREED;
         sp_in     = merge_at[CNTW-1:0];
         dd_in     = drop_n;
      end
      if (cmd.drop_wr) begin
         sp_in = sp_ff + CNTW'(1);
      end
      if (cmd.drop_end) begin
         count_in = count_ff - CNTW'(dd_ff);
      end
   end

   // working registers, control part cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         heap_top_ff <= '0;
      end else begin
         count_ff    <= count_in;
         heap_top_ff <= heap_top_in;
      end
      idx_ff      <= idx_in;
      sp_ff       <= sp_in;
      dd_ff       <= dd_in;
      off_ff      <= off_in;
      func_ff     <= func_in;
      want_ff     <= want_in;
      where_ff    <= where_in;
      prev_ff     <= prev_in;
      cur_size_ff <= cur_size_in;
      rest_ff     <= rest_in;
      status_ff   <= status_in;
      grant_ff    <= grant_in;
   end

   // result beat: grant offset, then segment count
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = status_ff;
         rsp_data_in  = RSP_TDATA_W'({count_ext[COUNT_OUT_W-1:0],
                                      (status_ff == RSP_ALLOCATED) ?
                                         grant_ff : {HANDLE_W{1'b0}}});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
